// ===== sv/bgs_pkg.sv =====
// Package for the button gesture and standby block.
// Holds the beat payload types, the event and request codes and the register indexes.
// No dependencies.
package bgs_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;

    // Configuration register indexes.
    localparam logic CFG_HOLD_TICKS   = 1'b0;
    localparam logic CFG_WINDOW_TICKS = 1'b1;

    localparam logic [CFG_W-1:0] HOLD_TICKS_RST   = 16'd300;
    localparam logic [CFG_W-1:0] WINDOW_TICKS_RST = 16'd250;

    // Event codes.
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_HOME     = 3'd1;
    localparam logic [2:0] EV_SWITCHER = 3'd2;
    localparam logic [2:0] EV_STANDBY  = 3'd3;
    localparam logic [2:0] EV_WOKE     = 3'd4;

    // External standby request codes.
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_ENTER = 2'd1;
    localparam logic [1:0] REQ_LEAVE = 2'd2;

    typedef struct packed {
        logic       button_down;
        logic       press_latched;
        logic [1:0] standby_request;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_res;
        logic       in_standby;
        logic       sleep_blocked;
    } t_out_item;

    // Control flags of the gesture state; the timer counts travel separately.
    typedef struct packed {
        logic       standby_flag;
        logic       wake_armed;
        logic       absorb_press;
        logic       press_held;
        logic       press_consumed;
        logic [1:0] click_count;
        logic       hold_active;
        logic       window_active;
    } t_flags;

endpackage

// ===== sv/bgs_in_if.sv =====
// Handshake channel carrying one input beat of the gesture block.
// Depends on bgs_pkg.
interface bgs_in_if import bgs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/bgs_out_if.sv =====
// Handshake channel carrying one result beat of the gesture block.
// Depends on bgs_pkg.
interface bgs_out_if import bgs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/bgs_step.sv =====
// Next-state and result logic for one tick of the gesture block.
// Purely combinational; depends on bgs_pkg.
module bgs_step import bgs_pkg::*; #(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  t_in_item                i_item,
    input  t_flags                  i_flags,
    input  logic [TIMER_BITS-1:0]   i_hold_cnt,
    input  logic [TIMER_BITS-1:0]   i_win_cnt,
    input  logic [CFG_W-1:0]        i_hold_ticks,
    input  logic [CFG_W-1:0]        i_window_ticks,
    output t_flags                  o_flags,
    output logic [TIMER_BITS-1:0]   o_hold_cnt,
    output logic [TIMER_BITS-1:0]   o_win_cnt,
    output t_out_item               o_res
);

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    t_flags                f;
    logic [TIMER_BITS-1:0] hc;
    logic [TIMER_BITS-1:0] wc;
    logic [2:0]            ev;
    logic [1:0]            n_clicks;
    logic [CMP_W-1:0]      hold_lim;
    logic [CMP_W-1:0]      win_lim;

    assign hold_lim = CMP_W'(i_hold_ticks);
    assign win_lim  = CMP_W'(i_window_ticks);

    always_comb begin
        f        = i_flags;
        hc       = i_hold_cnt;
        wc       = i_win_cnt;
        ev       = EV_NONE;
        n_clicks = 2'd0;

        // Timers first; the counters saturate at all ones.
        if (f.hold_active) begin
            if (!(&hc)) begin
                hc = hc + 1'b1;
            end
            if (CMP_W'(hc) >= hold_lim) begin
                f.hold_active    = 1'b0;
                hc               = '0;
                f.press_consumed = 1'b1;
                f.press_held     = 1'b0;
                f.absorb_press   = 1'b1;
                f.window_active  = 1'b0;
                wc               = '0;
                f.click_count    = 2'd0;
                if (!f.standby_flag) begin
                    f.standby_flag = 1'b1;
                    if (!i_item.button_down) begin
                        f.wake_armed = 1'b1;
                    end
                    ev = EV_STANDBY;
                end
            end
        end
        if (f.window_active) begin
            if (!(&wc)) begin
                wc = wc + 1'b1;
            end
            if (CMP_W'(wc) >= win_lim) begin
                f.window_active = 1'b0;
                wc              = '0;
                if (f.click_count == 2'd1) begin
                    ev = EV_HOME;
                end
                f.click_count = 2'd0;
            end
        end

        // External request.
        case (i_item.standby_request)
            REQ_ENTER: begin
                if (!f.standby_flag) begin
                    f.standby_flag  = 1'b1;
                    f.window_active = 1'b0;
                    wc              = '0;
                    f.click_count   = 2'd0;
                    if (!i_item.button_down) begin
                        f.wake_armed = 1'b1;
                    end
                    ev = EV_STANDBY;
                end
            end
            REQ_LEAVE: begin
                if (f.standby_flag) begin
                    f.standby_flag = 1'b0;
                    f.wake_armed   = 1'b0;
                    ev             = EV_WOKE;
                end
            end
            default: ;
        endcase

        // Button sample.
        if (f.absorb_press) begin
            if (!i_item.button_down) begin
                f.absorb_press = 1'b0;
                if (f.standby_flag) begin
                    f.wake_armed = 1'b1;
                end
            end
        end else if (f.standby_flag) begin
            if (!f.wake_armed) begin
                if (!i_item.button_down) begin
                    f.wake_armed = 1'b1;
                end
            end else if (i_item.button_down || i_item.press_latched) begin
                f.standby_flag = 1'b0;
                f.wake_armed   = 1'b0;
                ev             = EV_WOKE;
                if (i_item.button_down) begin
                    f.absorb_press = 1'b1;
                end
            end
        end else if (i_item.button_down) begin
            if (!f.press_held) begin
                f.press_held     = 1'b1;
                f.press_consumed = 1'b0;
                f.window_active  = 1'b0;
                wc               = '0;
                f.hold_active    = 1'b1;
                hc               = '0;
            end
        end else begin
            f.hold_active = 1'b0;
            hc            = '0;
            if (f.press_held && !f.press_consumed) begin
                n_clicks = f.click_count + 2'd1;
                if (n_clicks >= 2'd2) begin
                    f.click_count   = 2'd0;
                    f.window_active = 1'b0;
                    wc              = '0;
                    ev              = EV_SWITCHER;
                end else begin
                    f.click_count   = n_clicks;
                    f.window_active = 1'b1;
                    wc              = '0;
                end
            end
            f.press_held = 1'b0;
        end

        o_flags              = f;
        o_hold_cnt           = hc;
        o_win_cnt            = wc;
        o_res.event_res      = ev;
        o_res.in_standby     = f.standby_flag;
        o_res.sleep_blocked  = f.standby_flag && !f.wake_armed;
    end

endmodule

// ===== sv/button_gesture_standby_fsm_top.sv =====
// Top level of the button gesture and standby block.
// Depends on bgs_pkg, bgs_in_if, bgs_out_if and bgs_step.
//
// The block takes one beat per millisecond tick, carrying the button level, a
// flag for a press caught while asleep and an external standby request, and
// returns exactly one result beat for each: the gesture event (none, home,
// switcher, entered standby or woke) together with the standby state and
// whether standby is still waiting for its wake source to be armed. A beat is
// taken into an input register and then, through the flag and counter logic
// that updates the gesture state, into the result register, so a new beat can
// be taken on every clock cycle as long as the output is not stalled. The input
// register keeps accepting while a result waits to be taken, provided the
// result register can move on in the same cycle. The hold
// and click-window timers are TIMER_BITS wide and saturate; a timer whose
// register value lies beyond its range never expires. The two timing
// registers are written through the plain write port and should only be
// changed while no beat is in flight.
module button_gesture_standby_fsm_top import bgs_pkg::*; #(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    bgs_in_if.sink           i_item,
    bgs_out_if.source        o_res
);

    // Timing registers.
    logic [CFG_W-1:0]      r_hold_ticks;
    logic [CFG_W-1:0]      r_window_ticks;

    // Input register.
    logic                  r_in_valid;
    t_in_item              r_in;

    // Gesture state.
    t_flags                r_flags;
    logic [TIMER_BITS-1:0] r_hold_cnt;
    logic [TIMER_BITS-1:0] r_win_cnt;

    // Result register.
    logic                  r_out_valid;
    t_out_item             r_out;

    t_flags                n_flags;
    logic [TIMER_BITS-1:0] n_hold_cnt;
    logic [TIMER_BITS-1:0] n_win_cnt;
    t_out_item             n_out;

    logic                  advance;

    // The buffered beat moves on when the result register is empty or being
    // emptied in this cycle.
    assign advance      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || advance;

    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    bgs_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_item         (r_in),
        .i_flags        (r_flags),
        .i_hold_cnt     (r_hold_cnt),
        .i_win_cnt      (r_win_cnt),
        .i_hold_ticks   (r_hold_ticks),
        .i_window_ticks (r_window_ticks),
        .o_flags        (n_flags),
        .o_hold_cnt     (n_hold_cnt),
        .o_win_cnt      (n_win_cnt),
        .o_res          (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks   <= HOLD_TICKS_RST;
            r_window_ticks <= WINDOW_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOLD_TICKS:   r_hold_ticks   <= i_cfg_data;
                CFG_WINDOW_TICKS: r_window_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in <= i_item.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags    <= '0;
            r_hold_cnt <= '0;
            r_win_cnt  <= '0;
        end else if (advance) begin
            r_flags    <= n_flags;
            r_hold_cnt <= n_hold_cnt;
            r_win_cnt  <= n_win_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
